/* design/tts_pkg.sv */
// ----------------------------------------------------------------------------
// Task table scheduler package
// Shared widths, codes and the packed layout of one task slot entry.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIV_STEPS   = 32;

    // Input modes.
    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_SCHEDULE = 3'd1;
    localparam logic [2:0] MODE_SLEEP    = 3'd2;
    localparam logic [2:0] MODE_WAKE     = 3'd3;
    localparam logic [2:0] MODE_BLOCK    = 3'd4;
    localparam logic [2:0] MODE_UNBLOCK  = 3'd5;

    // Task states.
    localparam logic [2:0] ST_READY    = 3'd0;
    localparam logic [2:0] ST_RUNNING  = 3'd1;
    localparam logic [2:0] ST_BLOCKED  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_DEAD     = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_JIFFY = 1'b0;
    localparam logic CFG_IDLE  = 1'b1;

    typedef struct packed {
        logic [2:0]  state;
        logic [31:0] ticks;
        logic [31:0] last_run;
        logic [7:0]  prio;
    } slot_word_t;

endpackage

/* design/tts_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/task_table_scheduler.sv */
// ----------------------------------------------------------------------------
// Task table scheduler
// Keeps a 64-slot task table in RAM and runs write, schedule, sleep, wake,
// block and unblock items through a small sequencer around one RAM port pair.
// ----------------------------------------------------------------------------
// Sequence: a write answers directly; an unblock or non-switching block does a
//   read-modify-write; a wake sweeps the table; a schedule scans it, then rewrites
//   the current and next slots; a sleep (32 divider steps) or running-task block adds
//   a schedule.
// Throughput: one item at a time, the next taken in the cycle after the result beat;
//   scan and wake sweep read one slot per cycle from the single read port.
// Reset: all valid bits, the current slot and the registers' defaults are set
//   at once; the table contents are left undefined until written.
module task_table_scheduler (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [5:0]            slot,
    input  logic                  entry_valid,
    input  logic [2:0]            entry_state,
    input  logic [31:0]           entry_ticks,
    input  logic [31:0]           entry_last_run,
    input  logic [7:0]            entry_priority,
    input  logic [31:0]           sleep_ms,
    input  logic [31:0]           now_tick,
    input  logic [2:0]            block_state,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [5:0]            next_slot,
    output logic                  switched,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [9:0]            cfg_data
);

    import tts_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_WAKE = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_RD   = 7'b0010000,
        S_WB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } seq_state_t;

    // Which read-modify-write the S_RD/S_WB pair performs.
    typedef enum logic [2:0] {
        OP_UNBLOCK,
        OP_BLOCK,
        OP_SLEEP,
        OP_CUR,
        OP_NXT
    } rmw_op_t;

    seq_state_t         state_reg;
    rmw_op_t            op_reg;
    logic [9:0]         jiffy_reg;
    logic [5:0]         idle_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]   current_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [2:0]         blk_reg;
    logic [31:0]        now_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               p_v_reg;
    logic [IDX_W-1:0]   p_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_reg;
    logic [31:0]        best_ticks_reg;
    logic [31:0]        best_last_reg;
    logic [IDX_W-1:0]   rmw_addr_reg;
    logic [31:0]        quo_reg;
    logic [9:0]         rem_reg;
    logic               out_valid_reg;
    logic               switched_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    slot_word_t         ram_wdata;
    slot_word_t         ram_rdata;
    slot_word_t         mod_word;

    logic [9:0]         divisor;
    logic [10:0]        trial;
    logic [31:0]        sleep_ticks;
    logic               accept;
    logic               cand;

    tts_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign next_slot = current_reg;
    assign switched  = switched_reg;

    // Restoring divider step: a zero jiffy divides as one.
    assign divisor     = (jiffy_reg == 10'd0) ? 10'd1 : jiffy_reg;
    assign trial       = {rem_reg, quo_reg[31]} - {1'b0, divisor};
    assign sleep_ticks = now_reg + ((quo_reg == 32'd0) ? 32'd1 : quo_reg);

    // A scanned slot qualifies when it is valid, ready and not the running one.
    assign cand = p_v_reg && valid_reg[p_idx_reg] && (ram_rdata.state == ST_READY)
                  && (p_idx_reg != current_reg);

    // New contents of the slot under read-modify-write.
    always_comb
    begin
        mod_word = ram_rdata;
        case (op_reg)
            OP_UNBLOCK: mod_word.state = ST_READY;
            OP_BLOCK:   mod_word.state = blk_reg;
            OP_SLEEP:
            begin
                mod_word.ticks = sleep_ticks;
                mod_word.state = ST_SLEEPING;
            end
            OP_CUR:
            begin
                if (ram_rdata.ticks == 32'd0)
                begin
                    mod_word.ticks = {24'd0, ram_rdata.prio};
                end
                if (ram_rdata.state == ST_RUNNING)
                begin
                    mod_word.state = ST_READY;
                end
            end
            OP_NXT:
            begin
                if (ram_rdata.state == ST_SLEEPING)
                begin
                    mod_word.ticks = {24'd0, ram_rdata.prio};
                end
                mod_word.state = ST_RUNNING;
            end
            default: mod_word = ram_rdata;
        endcase
    end

    // RAM port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = '{state: entry_state, ticks: entry_ticks,
                      last_run: entry_last_run, prio: entry_priority};
        ram_raddr = cnt_reg[IDX_W-1:0];
        if (state_reg == S_IDLE)
        begin
            ram_we = in_valid && (mode == MODE_WRITE);
        end
        else if (state_reg == S_WAKE)
        begin
            ram_waddr = p_idx_reg;
            ram_wdata = ram_rdata;
            ram_wdata.ticks = {24'd0, ram_rdata.prio};
            ram_wdata.state = ST_READY;
            ram_we = p_v_reg && (ram_rdata.state == ST_SLEEPING)
                     && (ram_rdata.ticks <= now_reg);
        end
        else if (state_reg == S_RD)
        begin
            ram_raddr = rmw_addr_reg;
        end
        else if (state_reg == S_WB)
        begin
            ram_we    = 1'b1;
            ram_waddr = rmw_addr_reg;
            ram_wdata = mod_word;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_UNBLOCK;
            jiffy_reg     <= 10'd10;
            idle_reg      <= '0;
            valid_reg     <= '0;
            current_reg   <= '0;
            cnt_reg       <= '0;
            p_v_reg       <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            switched_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_JIFFY)
                begin
                    jiffy_reg <= cfg_data;
                end
                else
                begin
                    idle_reg <= cfg_data[5:0];
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg     <= slot;
                        blk_reg      <= block_state;
                        now_reg      <= now_tick;
                        quo_reg      <= sleep_ms;
                        rem_reg      <= '0;
                        cnt_reg      <= '0;
                        p_v_reg      <= 1'b0;
                        found_reg    <= 1'b0;
                        switched_reg <= 1'b0;
                        rmw_addr_reg <= slot;
                        case (mode)
                            MODE_WRITE:
                            begin
                                valid_reg[slot] <= entry_valid;
                                if (entry_state == ST_RUNNING)
                                begin
                                    current_reg <= slot;
                                end
                                state_reg     <= S_OUT;
                                out_valid_reg <= 1'b1;
                            end
                            MODE_SCHEDULE: state_reg <= S_SCAN;
                            MODE_SLEEP:    state_reg <= S_DIV;
                            MODE_WAKE:     state_reg <= S_WAKE;
                            MODE_BLOCK:
                            begin
                                if (block_state >= ST_BLOCKED && block_state <= ST_DEAD)
                                begin
                                    op_reg    <= OP_BLOCK;
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    state_reg     <= S_OUT;
                                    out_valid_reg <= 1'b1;
                                end
                            end
                            MODE_UNBLOCK:
                            begin
                                op_reg    <= OP_UNBLOCK;
                                state_reg <= S_RD;
                            end
                            default:
                            begin
                                state_reg     <= S_OUT;
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end

                S_DIV:
                begin
                    if (!trial[10])
                    begin
                        rem_reg <= trial[9:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[8:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        op_reg       <= OP_SLEEP;
                        rmw_addr_reg <= current_reg;
                        state_reg    <= S_RD;
                    end
                end

                S_WAKE:
                begin
                    p_v_reg   <= (cnt_reg < CNT_W'(TABLE_DEPTH));
                    p_idx_reg <= cnt_reg[IDX_W-1:0];
                    if (cnt_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        cnt_reg       <= '0;
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end

                S_SCAN:
                begin
                    p_v_reg   <= (cnt_reg < CNT_W'(TABLE_DEPTH));
                    p_idx_reg <= cnt_reg[IDX_W-1:0];
                    if (cand && (!found_reg || best_ticks_reg < ram_rdata.ticks
                                 || best_last_reg > ram_rdata.last_run))
                    begin
                        found_reg      <= 1'b1;
                        best_reg       <= p_idx_reg;
                        best_ticks_reg <= ram_rdata.ticks;
                        best_last_reg  <= ram_rdata.last_run;
                    end
                    if (cnt_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        cnt_reg      <= '0;
                        op_reg       <= OP_CUR;
                        rmw_addr_reg <= current_reg;
                        state_reg    <= S_RD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end

                S_RD:
                begin
                    state_reg <= S_WB;
                end

                S_WB:
                begin
                    case (op_reg)
                        OP_BLOCK:
                        begin
                            if (slot_reg == current_reg)
                            begin
                                cnt_reg   <= '0;
                                p_v_reg   <= 1'b0;
                                state_reg <= S_SCAN;
                            end
                            else
                            begin
                                state_reg     <= S_OUT;
                                out_valid_reg <= 1'b1;
                            end
                        end
                        OP_SLEEP:
                        begin
                            cnt_reg   <= '0;
                            p_v_reg   <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                        OP_CUR:
                        begin
                            op_reg       <= OP_NXT;
                            rmw_addr_reg <= found_reg ? best_reg : idle_reg;
                            state_reg    <= S_RD;
                        end
                        OP_NXT:
                        begin
                            current_reg   <= rmw_addr_reg;
                            switched_reg  <= 1'b1;
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        default:
                        begin
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                    endcase
                end

                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The block never takes an item while a result beat is still pending.
    assert property (@(posedge clk) disable iff (!rst_n) in_ready |-> !out_valid)
        else $error("input ready while a result beat is pending");

    // An accepted item always takes the sequencer out of idle in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_ready)
        else $error("sequencer did not leave idle after accept");

    // The sweep counter never runs past the table.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("sweep counter overran the table");

endmodule

/* verif/task_table_scheduler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table scheduler checker
// Watches the input, output and register ports of the scheduler, keeps its
// own copy of the task table, predicts one result per accepted input beat and
// compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module task_table_scheduler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [5:0]  slot,
    input  logic        entry_valid,
    input  logic [2:0]  entry_state,
    input  logic [31:0] entry_ticks,
    input  logic [31:0] entry_last_run,
    input  logic [7:0]  entry_priority,
    input  logic [31:0] sleep_ms,
    input  logic [31:0] now_tick,
    input  logic [2:0]  block_state,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  next_slot,
    input  logic        switched,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    output int          errors,
    output int          pending
);

    import tts_pkg::*;

    typedef struct packed {
        logic [5:0] next_slot;
        logic       switched;
    } decision_t;

    logic        tbl_valid [TABLE_DEPTH];
    logic [2:0]  tbl_state [TABLE_DEPTH];
    logic [31:0] tbl_ticks [TABLE_DEPTH];
    logic [31:0] tbl_last  [TABLE_DEPTH];
    logic [7:0]  tbl_prio  [TABLE_DEPTH];
    logic [5:0]  running_slot;
    logic [9:0]  jiffy;
    logic [5:0]  idle_pick;

    decision_t   decisions [$];

    // Picks the next task and performs the state hand-over between slots.
    task automatic pick_next_task();
        int         best;
        bit         found;
        logic [5:0] old;
        logic [5:0] nxt;
        best  = 0;
        found = 0;
        old   = running_slot;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (tbl_valid[i] && tbl_state[i] == ST_READY && i != old) begin
                if (!found || tbl_ticks[best] < tbl_ticks[i] || tbl_last[best] > tbl_last[i])
                begin
                    best  = i;
                    found = 1;
                end
            end
        end
        nxt = found ? 6'(best) : idle_pick;
        if (tbl_ticks[old] == 32'd0)
            tbl_ticks[old] = 32'(tbl_prio[old]);
        if (tbl_state[old] == ST_RUNNING)
            tbl_state[old] = ST_READY;
        if (tbl_state[nxt] != ST_READY) begin
            if (tbl_state[nxt] == ST_SLEEPING)
                tbl_ticks[nxt] = 32'(tbl_prio[nxt]);
            tbl_state[nxt] = ST_READY;
        end
        tbl_state[nxt] = ST_RUNNING;
        running_slot   = nxt;
    endtask

    task automatic apply_item(output decision_t d);
        logic [31:0] div;
        logic [31:0] nap;
        d.switched = 1'b0;
        case (mode)
            MODE_WRITE: begin
                tbl_valid[slot] = entry_valid;
                tbl_state[slot] = entry_state;
                tbl_ticks[slot] = entry_ticks;
                tbl_last[slot]  = entry_last_run;
                tbl_prio[slot]  = entry_priority;
                if (entry_state == ST_RUNNING)
                    running_slot = slot;
            end
            MODE_SCHEDULE: begin
                pick_next_task();
                d.switched = 1'b1;
            end
            MODE_SLEEP: begin
                div = (jiffy == 10'd0) ? 32'd1 : 32'(jiffy);
                nap = sleep_ms / div;
                if (nap == 32'd0)
                    nap = 32'd1;
                tbl_ticks[running_slot] = now_tick + nap;
                tbl_state[running_slot] = ST_SLEEPING;
                pick_next_task();
                d.switched = 1'b1;
            end
            MODE_WAKE: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_state[i] == ST_SLEEPING && tbl_ticks[i] <= now_tick) begin
                        tbl_ticks[i] = 32'(tbl_prio[i]);
                        tbl_state[i] = ST_READY;
                    end
                end
            end
            MODE_BLOCK: begin
                if (block_state >= ST_BLOCKED && block_state <= ST_DEAD) begin
                    tbl_state[slot] = block_state;
                    if (slot == running_slot) begin
                        pick_next_task();
                        d.switched = 1'b1;
                    end
                end
            end
            MODE_UNBLOCK: tbl_state[slot] = ST_READY;
            default: ;
        endcase
        d.next_slot = running_slot;
    endtask

    always @(posedge clk or negedge rst_n) begin
        decision_t d;
        decision_t want;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_state[i] = ST_READY;
                tbl_ticks[i] = '0;
                tbl_last[i]  = '0;
                tbl_prio[i]  = '0;
            end
            running_slot = '0;
            jiffy        = 10'd10;
            idle_pick    = '0;
            errors       = 0;
            decisions.delete();
            pending      = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_JIFFY)
                    jiffy = cfg_data;
                else
                    idle_pick = cfg_data[5:0];
            end
            if (in_valid && in_ready) begin
                apply_item(d);
                decisions.push_back(d);
            end
            if (out_valid && out_ready) begin
                if (decisions.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat next_slot=%0d switched=%0d",
                             $time, next_slot, switched);
                end else begin
                    want = decisions.pop_front();
                    if (next_slot !== want.next_slot) begin
                        errors++;
                        $display("%0t: next_slot expected %0d actual %0d",
                                 $time, want.next_slot, next_slot);
                    end
                    if (switched !== want.switched) begin
                        errors++;
                        $display("%0t: switched expected %0d actual %0d",
                                 $time, want.switched, switched);
                    end
                end
            end
            pending = decisions.size();
        end
    end

endmodule

/* verif/task_table_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task table scheduler testbench
// Fills the whole task table first so that no undefined entry is ever read,
// then runs directed items over every mode and edge value, followed by three
// random phases with different idle patterns and register settings. A
// separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module task_table_scheduler_test;
    import tts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = MODE_WRITE;
    logic [5:0]  slot = '0;
    logic        entry_valid = 1'b0;
    logic [2:0]  entry_state = ST_READY;
    logic [31:0] entry_ticks = '0;
    logic [31:0] entry_last_run = '0;
    logic [7:0]  entry_priority = '0;
    logic [31:0] sleep_ms = '0;
    logic [31:0] now_tick = '0;
    logic [2:0]  block_state = ST_BLOCKED;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  next_slot;
    logic        switched;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_JIFFY;
    logic [9:0]  cfg_data = '0;

    int errors;
    int pending;
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    always #5 clk = ~clk;

    task_table_scheduler dut (.*);

    task_table_scheduler_checker checker_i (.*);

    // The receiver throttles the result channel on its own.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // Any accepted beat on either channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("task_table_scheduler_test: done, errors");
            $finish;
        end
    end

    // Mostly small numbers so that tick and last-run ties happen, plus edges.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(3));
            3: return 32'($urandom_range(40));
            default: return $urandom;
        endcase
    endfunction

    // Sends one beat; called at a rising edge and returns at the accept edge.
    task automatic send_beat(input logic [2:0] m, input logic [5:0] s, input logic ev,
                             input logic [2:0] es, input logic [31:0] et,
                             input logic [31:0] el, input logic [7:0] ep,
                             input logic [31:0] ms, input logic [31:0] nt,
                             input logic [2:0] bs);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= m;
        slot           <= s;
        entry_valid    <= ev;
        entry_state    <= es;
        entry_ticks    <= et;
        entry_last_run <= el;
        entry_priority <= ep;
        sleep_ms       <= ms;
        now_tick       <= nt;
        block_state    <= bs;
        // Ready is stable by the falling edge, so sample it there.
        forever begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
    endtask

    task automatic send_write(input logic [5:0] s, input logic ev, input logic [2:0] es,
                              input logic [31:0] et, input logic [31:0] el,
                              input logic [7:0] ep);
        send_beat(MODE_WRITE, s, ev, es, et, el, ep, $urandom, $urandom,
                  3'($urandom_range(2, 5)));
    endtask

    task automatic send_random_item();
        logic [2:0] m;
        logic [2:0] es;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30)
            m = MODE_WRITE;
        else if (pick < 50)
            m = MODE_SCHEDULE;
        else if (pick < 62)
            m = MODE_SLEEP;
        else if (pick < 76)
            m = MODE_WAKE;
        else if (pick < 88)
            m = MODE_BLOCK;
        else
            m = MODE_UNBLOCK;
        // Most written slots are ready so that the scan has real candidates.
        es = ($urandom_range(2) != 0) ? ST_READY : 3'($urandom_range(5));
        send_beat(m, 6'($urandom_range(63)), ($urandom_range(3) != 0), es, pick_word(),
                  pick_word(), 8'($urandom), pick_word(), pick_word(),
                  3'($urandom_range(2, 5)));
    endtask

    // Registers change only with the block idle and nothing in flight. The
    // first edge lets the checker see the last accepted beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input int count,
                                input logic [9:0] jiffy, input logic [5:0] idle);
        drain();
        write_reg(CFG_JIFFY, jiffy);
        write_reg(CFG_IDLE, {4'd0, idle});
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int n = 0; n < count; n++) begin
            send_random_item();
            // Hold the sender once until every pending result is back.
            if (n == count / 2)
                drain();
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_JIFFY, 10'd1);
        write_reg(CFG_IDLE, 10'd63);

        // Every slot gets written once so later sweeps read defined entries.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_write(6'(i), 1'($urandom), (i == 0) ? ST_RUNNING : 3'($urandom_range(5)),
                       pick_word(), pick_word(), 8'($urandom));

        // Directed: extremes, ties, every mode and every block state.
        send_write(6'd1, 1'b1, ST_READY, 32'hFFFF_FFFF, 32'd0, 8'hFF);
        send_write(6'd2, 1'b1, ST_READY, 32'hFFFF_FFFF, 32'd0, 8'h00);
        send_write(6'd63, 1'b1, ST_READY, 32'd0, 32'hFFFF_FFFF, 8'h80);
        send_beat(MODE_SCHEDULE, '0, 1'b0, ST_READY, '0, '0, '0, '0, '0, ST_BLOCKED);
        send_beat(MODE_SLEEP, '0, 1'b0, ST_READY, '0, '0, '0, 32'd0, 32'hFFFF_FFFF,
                  ST_BLOCKED);
        send_beat(MODE_SLEEP, '0, 1'b0, ST_READY, '0, '0, '0, 32'hFFFF_FFFF,
                  32'd5, ST_BLOCKED);
        send_beat(MODE_WAKE, '0, 1'b0, ST_READY, '0, '0, '0, '0, 32'd0, ST_BLOCKED);
        send_beat(MODE_WAKE, '0, 1'b0, ST_READY, '0, '0, '0, '0, 32'hFFFF_FFFF,
                  ST_BLOCKED);
        for (int b = 2; b <= 5; b++)
            send_beat(MODE_BLOCK, 6'($urandom_range(63)), 1'b0, ST_READY, '0, '0, '0,
                      '0, '0, 3'(b));
        // Blocking the running slot forces a switch.
        send_write(6'd5, 1'b1, ST_RUNNING, 32'd0, 32'd7, 8'd9);
        send_beat(MODE_BLOCK, 6'd5, 1'b0, ST_READY, '0, '0, '0, '0, '0, ST_SLEEPING);
        send_beat(MODE_UNBLOCK, 6'd5, 1'b0, ST_READY, '0, '0, '0, '0, '0, ST_BLOCKED);
        send_beat(MODE_UNBLOCK, 6'd63, 1'b0, ST_READY, '0, '0, '0, '0, '0, ST_BLOCKED);

        random_phase(31, 84, 110, 10'd1000, 6'd0);
        random_phase(84, 31, 110, 10'($urandom_range(1, 1000)), 6'($urandom_range(63)));
        random_phase(0, 0, 120, 10'd7, 6'd63);

        drain();
        if (errors == 0)
            $display("task_table_scheduler_test: done, clean");
        else
            $display("task_table_scheduler_test: done, errors");
        $finish;
    end

endmodule
